>>> sv/bmst_pkg.sv
package bmst_pkg;

    localparam int unsigned WORD_BITS    = 64;
    localparam int unsigned SHIFT_W      = 6;
    localparam int unsigned POS_W        = 12;
    localparam int unsigned WORD_W       = POS_W - SHIFT_W;
    localparam int unsigned ADDR_WORDS   = (2 ** POS_W) / WORD_BITS;
    localparam int unsigned MAX_BITS_DEF = 4096;

    localparam int unsigned CFG_W        = 13;
    localparam int unsigned CFG_MAX      = (2 ** CFG_W) - 1;
    localparam logic [CFG_W-1:0] BITS_IN_USE_RST = 13'd4096;

    localparam int unsigned PADDR_W      = 3;
    localparam int unsigned PDATA_W      = 32;
    localparam int unsigned REG_IDX_W    = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_BITS_IN_USE = 1'b0;

    localparam int unsigned QUEUE_DEPTH  = 2;
    localparam int unsigned QPTR_W       = 1;
    localparam int unsigned QCNT_W       = 2;

    typedef enum logic [1:0] {
        CMD_SET_BIT   = 2'd0,
        CMD_TEST_BIT  = 2'd1,
        CMD_SET_MASK  = 2'd2,
        CMD_TEST_MASK = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        MSZ_8  = 2'd0,
        MSZ_16 = 2'd1,
        MSZ_32 = 2'd2,
        MSZ_64 = 2'd3
    } t_msize;

    typedef struct packed {
        t_cmd                 command;
        logic [POS_W-1:0]     position;
        logic [WORD_BITS-1:0] mask_value;
        t_msize               mask_size;
    } t_in_item;

    typedef struct packed {
        logic accepted;
        logic all_set;
    } t_out_item;

    // One classified item on its way from the front end to the store sequencer
    typedef struct packed {
        logic                 ok;
        logic                 test;
        logic                 spill;
        logic                 next_ok;
        logic [WORD_W-1:0]    word;
        logic [WORD_BITS-1:0] low;
        logic [WORD_BITS-1:0] high;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CHECK0,
        BK_CHECK1
    } t_bk_state;

endpackage

>>> sv/bitmap_mask_set_test.sv
// Bit store of 64-bit words, all clear after reset, serving set bit, test bit, set mask
// and test mask commands; a mask of 8, 16, 32 or 64 bits may sit at any bit position
// and may be split over two adjacent words. Every item gives one result: accepted is
// low when the bits touched reach past bits_in_use (APB register at address 0), and
// all_set reports a test. The front end classifies items into a two-entry queue; the
// back end works them one at a time through a word memory with one read and one write
// port, stepping from idle through a check of the addressed word and, only when a mask
// spills into the next word, a check of that word; a rejected item never checks the next word.
module bitmap_mask_set_test #(
    parameter int unsigned MAX_BITS = bmst_pkg::MAX_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  bmst_pkg::t_in_item           i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output bmst_pkg::t_out_item          o_out_item,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bmst_pkg::PADDR_W-1:0] paddr,
    input  logic [bmst_pkg::PDATA_W-1:0] pwdata,
    output logic [bmst_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    import bmst_pkg::*;

    localparam int unsigned WORD_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    // a mask at the top position may spill one word past the addressable range
    localparam int unsigned DEPTH      = (WORD_COUNT < ADDR_WORDS + 1) ? WORD_COUNT
                                                                       : ADDR_WORDS + 1;

    logic [CFG_W-1:0]     r_bits_in_use;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 push;
    logic                 pop;
    logic                 full;
    logic                 empty;
    t_job                 front_job;
    t_job                 head_job;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits_in_use <= BITS_IN_USE_RST;
        end else if (psel && penable && pwrite && pready && (reg_idx == REG_BITS_IN_USE)) begin
            r_bits_in_use <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (reg_idx == REG_BITS_IN_USE) ? PDATA_W'(r_bits_in_use) : '0;

    bmst_front #(
        .MAX_BITS (MAX_BITS)
    ) u_front (
        .i_bits_in_use (r_bits_in_use),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_item     (i_in_item),
        .i_full        (full),
        .o_push        (push),
        .o_job         (front_job)
    );

    bmst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (empty)
    );

    bmst_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!empty),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

>>> sv/bmst_ram.sv
module bmst_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/bmst_front.sv
module bmst_front #(
    parameter int unsigned MAX_BITS = bmst_pkg::MAX_BITS_DEF
) (
    input  logic [bmst_pkg::CFG_W-1:0] i_bits_in_use,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  bmst_pkg::t_in_item         i_in_item,
    input  logic                       i_full,
    output logic                       o_push,
    output bmst_pkg::t_job             o_job
);

    import bmst_pkg::*;

    localparam int unsigned WORD_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned LIMIT_CAP  = (MAX_BITS > CFG_MAX) ? CFG_MAX : MAX_BITS;

    logic                   is_mask;
    logic [CFG_W-1:0]       width;
    logic [CFG_W-1:0]       limit;
    logic [CFG_W-1:0]       span;
    logic [WORD_BITS-1:0]   mask;
    logic [2*WORD_BITS-1:0] shifted;
    logic [SHIFT_W-1:0]     shift;
    logic [WORD_W-1:0]      word;

    always_comb begin
        is_mask = (i_in_item.command inside {CMD_SET_MASK, CMD_TEST_MASK});
        case (i_in_item.mask_size)
            MSZ_8: begin
                width = CFG_W'(8);
                mask  = WORD_BITS'(i_in_item.mask_value[7:0]);
            end
            MSZ_16: begin
                width = CFG_W'(16);
                mask  = WORD_BITS'(i_in_item.mask_value[15:0]);
            end
            MSZ_32: begin
                width = CFG_W'(32);
                mask  = WORD_BITS'(i_in_item.mask_value[31:0]);
            end
            MSZ_64: begin
                width = CFG_W'(64);
                mask  = i_in_item.mask_value;
            end
            default: begin
                width = CFG_W'(64);
                mask  = i_in_item.mask_value;
            end
        endcase
        if (!is_mask) begin
            width = CFG_W'(1);
            mask  = WORD_BITS'(1);
        end

        limit   = (i_bits_in_use > CFG_W'(LIMIT_CAP)) ? CFG_W'(LIMIT_CAP) : i_bits_in_use;
        span    = CFG_W'(i_in_item.position) + width;
        word    = i_in_item.position[POS_W-1:SHIFT_W];
        shift   = i_in_item.position[SHIFT_W-1:0];
        // low half lands in the addressed word, high half spills into the next one
        shifted = {{WORD_BITS{1'b0}}, mask} << shift;

        o_job.ok      = (span <= limit);
        o_job.test    = (i_in_item.command inside {CMD_TEST_BIT, CMD_TEST_MASK});
        o_job.high    = shifted[2*WORD_BITS-1:WORD_BITS];
        o_job.low     = shifted[WORD_BITS-1:0];
        o_job.spill   = (shifted[2*WORD_BITS-1:WORD_BITS] != '0);
        o_job.next_ok = ((32'(word) + 32'd1) < WORD_COUNT);
        o_job.word    = word;
    end

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

endmodule

>>> sv/bmst_queue.sv
module bmst_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bmst_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output bmst_pkg::t_job o_job,
    output logic           o_empty
);

    import bmst_pkg::*;

    t_job              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_job   = r_slot[r_rd_ptr];
    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);

endmodule

>>> sv/bmst_back.sv
module bmst_back #(
    parameter int unsigned DEPTH = bmst_pkg::ADDR_WORDS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  bmst_pkg::t_job      i_job,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bmst_pkg::t_out_item o_out_item
);

    import bmst_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_bk_state            r_state;
    t_bk_state            n_state;
    t_job                 r_job;
    logic                 r_lo_ok;
    logic                 r_rd_valid;
    logic [DEPTH-1:0]     r_valid;
    logic                 r_out_valid;
    t_out_item            r_out_item;

    logic                 start;
    logic                 second;
    logic [AW-1:0]        word_a;
    logic [AW-1:0]        word_b;
    logic [AW-1:0]        raddr;
    logic [AW-1:0]        waddr;
    logic                 we;
    logic [WORD_BITS-1:0] wdata;
    logic [WORD_BITS-1:0] rdata;
    logic [WORD_BITS-1:0] rd_word;
    logic                 hit_lo;
    logic                 hit_hi;
    logic                 finish;
    t_out_item            result;

    bmst_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // A word never written since reset reads as zero
    assign rd_word = r_rd_valid ? rdata : '0;
    assign word_a  = AW'(r_job.word);
    assign word_b  = AW'(word_a + 1'b1);
    assign hit_lo  = ((rd_word & r_job.low) == r_job.low);
    assign hit_hi  = ((rd_word & r_job.high) == r_job.high);
    assign second  = r_job.ok && r_job.spill && r_job.next_ok;
    // only start when the result register is sure to be free at the end
    assign start   = i_job_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (start) begin
                    n_state = BK_CHECK0;
                end
            end
            BK_CHECK0: begin
                n_state = second ? BK_CHECK1 : BK_IDLE;
            end
            BK_CHECK1: begin
                n_state = BK_IDLE;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop           = 1'b0;
        raddr           = AW'(i_job.word);
        we              = 1'b0;
        waddr           = word_a;
        wdata           = rd_word | r_job.low;
        finish          = 1'b0;
        result.accepted = 1'b0;
        result.all_set  = 1'b0;
        case (r_state)
            BK_IDLE: begin
                o_pop = start;
                raddr = AW'(i_job.word);
            end
            BK_CHECK0: begin
                raddr           = word_b;
                we              = r_job.ok && !r_job.test;
                waddr           = word_a;
                wdata           = rd_word | r_job.low;
                finish          = !second;
                result.accepted = r_job.ok;
                result.all_set  = r_job.ok && r_job.test && hit_lo
                                  && !(r_job.spill && !r_job.next_ok);
            end
            BK_CHECK1: begin
                we              = !r_job.test;
                waddr           = word_b;
                wdata           = rd_word | r_job.high;
                finish          = 1'b1;
                result.accepted = 1'b1;
                result.all_set  = r_job.test && r_lo_ok && hit_hi;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (r_state == BK_CHECK0) begin
            r_lo_ok <= hit_lo;
        end
        r_rd_valid <= r_valid[raddr];
        if (finish) begin
            r_out_item <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (we) begin
                r_valid[waddr] <= 1'b1;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> sv/bmst_checker.sv
module bmst_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input bmst_pkg::t_out_item i_out_item
);

    logic [3:0] r_pending;

    // items taken in and not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 4'((i_in_valid && i_in_ready) ? 1 : 0)
                                   - 4'((i_out_valid && i_out_ready) ? 1 : 0);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_item))
        else $error("result dropped or changed while stalled");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pending != 4'd0)
        else $error("result without an outstanding item");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 4'd4)
        else $error("more items in flight than the queue and stages hold");

    a_set_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_item.all_set && !i_out_item.accepted))
        else $error("all_set reported for a rejected item");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid straight after reset");

endmodule

bind bitmap_mask_set_test bmst_checker u_bmst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_item  (o_out_item)
);

>>> tb/bitmap_mask_set_test_test.sv
`timescale 1ns / 100ps

module bitmap_mask_set_test_test;

    import bmst_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 8;
    localparam logic [PADDR_W-1:0] ADDR_BITS_IN_USE = {REG_BITS_IN_USE, 2'b00};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_item             i_in_item;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out_item            o_out_item;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // mirror of the block: word store and size register
    logic [WORD_BITS-1:0] bit_store [ADDR_WORDS];
    logic [CFG_W-1:0]     size_reg;

    t_out_item            pending_outcomes [$];
    t_in_item             recent_sets [$];
    int unsigned          fail_count;
    bit                   no_idle;

    bitmap_mask_set_test u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int unsigned live_limit();
        return (size_reg > MAX_BITS_DEF) ? MAX_BITS_DEF : int'(size_reg);
    endfunction

    function automatic int unsigned item_width(t_in_item it);
        if (it.command == CMD_SET_BIT || it.command == CMD_TEST_BIT)
            return 1;
        return 8 << it.mask_size;
    endfunction

    // works out the result of one item and applies any set to the mirror
    function automatic t_out_item predict_outcome(t_in_item it);
        t_out_item            res;
        int unsigned          width;
        int unsigned          word;
        int unsigned          shift;
        logic [WORD_BITS-1:0] mask;
        logic [WORD_BITS-1:0] lo;
        logic [WORD_BITS-1:0] hi;
        bit                   is_test;
        bit                   ok;

        res = '0;
        width = item_width(it);
        if (it.command == CMD_SET_BIT || it.command == CMD_TEST_BIT)
            mask = 64'd1;
        else if (width >= 64)
            mask = it.mask_value;
        else
            mask = it.mask_value & ((64'd1 << width) - 64'd1);
        if (int'(it.position) + width > live_limit())
            return res;

        word  = it.position[POS_W-1:SHIFT_W];
        shift = it.position[SHIFT_W-1:0];
        lo = mask << shift;
        hi = (shift == 0) ? '0 : (mask >> (64 - shift));
        is_test = (it.command == CMD_TEST_BIT || it.command == CMD_TEST_MASK);

        if (is_test) begin
            ok = ((bit_store[word] & lo) == lo);
            if (hi != '0) begin
                if (word + 1 < ADDR_WORDS)
                    ok = ok && ((bit_store[word + 1] & hi) == hi);
                else
                    ok = 1'b0;
            end
            res.all_set = ok;
        end else begin
            bit_store[word] = bit_store[word] | lo;
            if (hi != '0 && word + 1 < ADDR_WORDS)
                bit_store[word + 1] = bit_store[word + 1] | hi;
        end
        res.accepted = 1'b1;
        return res;
    endfunction

    function automatic t_in_item make_item(t_cmd cmd, int unsigned pos,
                                           logic [WORD_BITS-1:0] val, t_msize sz);
        t_in_item it;
        it.command    = cmd;
        it.position   = pos[POS_W-1:0];
        it.mask_value = val;
        it.mask_size  = sz;
        return it;
    endfunction

    // mostly sets followed by tests of what was set, with some noise
    function automatic t_in_item random_request();
        t_in_item    it;
        int unsigned pick;
        int unsigned lim;
        int unsigned width;
        int          pos;

        pick = $urandom_range(0, 99);
        if (pick < 35 && recent_sets.size() > 0) begin
            it = recent_sets[$urandom_range(0, recent_sets.size() - 1)];
            it.command = (it.command == CMD_SET_BIT) ? CMD_TEST_BIT : CMD_TEST_MASK;
            if ($urandom_range(0, 3) == 0)
                it.mask_value[$urandom_range(0, 63)] ^= 1'b1;
            if ($urandom_range(0, 7) == 0)
                it.position = it.position + 1'b1;
            return it;
        end

        if (pick < 75)
            it.command = $urandom_range(0, 1) ? CMD_SET_MASK : CMD_SET_BIT;
        else if (pick < 90)
            it.command = $urandom_range(0, 1) ? CMD_TEST_MASK : CMD_TEST_BIT;
        else
            it.command = t_cmd'($urandom_range(0, 3));
        it.mask_size = t_msize'($urandom_range(0, 3));
        case ($urandom_range(0, 15))
            0:       it.mask_value = '0;
            1, 2:    it.mask_value = '1;
            default: it.mask_value = {$urandom, $urandom};
        endcase

        width = item_width(it);
        lim = live_limit();
        if (pick >= 90 || lim == 0) begin
            pos = $urandom_range(0, 4095);
        end else if ($urandom_range(0, 4) == 0) begin
            // straddle the end of the set
            pos = int'(lim) - int'(width) - 1 + int'($urandom_range(0, 2));
        end else begin
            pos = $urandom_range(0, (lim > width) ? lim - width : 0);
        end
        if (pos < 0)
            pos = 0;
        if (pos > 4095)
            pos = 4095;
        it.position = pos[POS_W-1:0];

        if (it.command == CMD_SET_BIT || it.command == CMD_SET_MASK) begin
            recent_sets.push_back(it);
            if (recent_sets.size() > 32)
                void'(recent_sets.pop_front());
        end
        return it;
    endfunction

    task automatic send_item(t_in_item it);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        pending_outcomes.push_back(predict_outcome(it));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read_check(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] want);
        logic [PDATA_W-1:0] got;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
                $display("read of size register: expected %0d, got %0d", want, got);
        end
    endtask

    task automatic set_size(logic [CFG_W-1:0] value);
        drain_results();
        apb_write(ADDR_BITS_IN_USE, PDATA_W'(value));
        size_reg = value;
        apb_read_check(ADDR_BITS_IN_USE, PDATA_W'(value));
    endtask

    // result side: per-item stall, in-order compare
    initial begin
        int unsigned stall;
        t_out_item   want;
        i_out_ready = 1'b0;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (pending_outcomes.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result with nothing expected: accepted %b all_set %b",
                                 o_out_item.accepted, o_out_item.all_set);
                end else begin
                    want = pending_outcomes.pop_front();
                    if (o_out_item.accepted !== want.accepted ||
                        o_out_item.all_set !== want.all_set) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result mismatch: expected accepted %b all_set %b, got %b %b",
                                     want.accepted, want.all_set,
                                     o_out_item.accepted, o_out_item.all_set);
                    end
                end
                stall = no_idle ? 0 : $urandom_range(0, 3);
                if (stall > 0)
                    i_out_ready <= 1'b0;
            end else if (!i_out_ready) begin
                if (stall > 0)
                    stall--;
                if (stall == 0)
                    i_out_ready <= 1'b1;
            end
        end
    end

    // reset size: edges of the store, spills, empty and oversized masks
    task automatic test_directed_items();
        send_item(make_item(CMD_TEST_BIT,  0,    '0, MSZ_8));
        send_item(make_item(CMD_TEST_BIT,  4095, '1, MSZ_64));
        send_item(make_item(CMD_TEST_MASK, 0,    '1, MSZ_64));
        send_item(make_item(CMD_TEST_MASK, 10,   64'hFFFF_FFFF_0000_0000, MSZ_32));
        send_item(make_item(CMD_SET_BIT,   0,    '1, MSZ_64));
        send_item(make_item(CMD_TEST_BIT,  0,    '0, MSZ_8));
        send_item(make_item(CMD_TEST_BIT,  1,    '1, MSZ_16));
        send_item(make_item(CMD_SET_BIT,   4095, '0, MSZ_32));
        send_item(make_item(CMD_TEST_BIT,  4095, '0, MSZ_8));
        send_item(make_item(CMD_SET_MASK,  4095, 64'hFF, MSZ_8));
        send_item(make_item(CMD_SET_MASK,  4088, 64'hFFFF_FFFF_FFFF_FFA5, MSZ_8));
        send_item(make_item(CMD_TEST_MASK, 4088, 64'hA5, MSZ_8));
        send_item(make_item(CMD_SET_MASK,  4032, '1, MSZ_64));
        send_item(make_item(CMD_TEST_MASK, 4032, '1, MSZ_64));
        send_item(make_item(CMD_TEST_MASK, 4033, '1, MSZ_64));
        send_item(make_item(CMD_SET_MASK,  100,  64'hFFFF_FFFF_DEAD_BEEF, MSZ_32));
        send_item(make_item(CMD_TEST_MASK, 100,  64'hDEAD_BEEF, MSZ_32));
        send_item(make_item(CMD_TEST_MASK, 100,  64'hFFFF_FFFF, MSZ_32));
        send_item(make_item(CMD_SET_MASK,  60,   64'h1234, MSZ_16));
        send_item(make_item(CMD_TEST_MASK, 60,   64'h1234, MSZ_16));
        send_item(make_item(CMD_SET_MASK,  3,    '1, MSZ_64));
        send_item(make_item(CMD_TEST_MASK, 1,    '1, MSZ_64));
        send_item(make_item(CMD_SET_MASK,  200,  '0, MSZ_64));
        send_item(make_item(CMD_TEST_BIT,  200,  '0, MSZ_8));
    endtask

    // size register: reset value, zero, one, above the maximum
    task automatic test_size_register();
        drain_results();
        apb_read_check(ADDR_BITS_IN_USE, PDATA_W'(BITS_IN_USE_RST));
        set_size('0);
        send_item(make_item(CMD_SET_BIT,   0, '0, MSZ_8));
        send_item(make_item(CMD_TEST_MASK, 0, '0, MSZ_8));
        set_size(13'd1);
        send_item(make_item(CMD_TEST_BIT,  0, '0, MSZ_8));
        send_item(make_item(CMD_SET_BIT,   1, '0, MSZ_8));
        send_item(make_item(CMD_TEST_MASK, 0, '0, MSZ_8));
        set_size(CFG_W'(CFG_MAX));
        send_item(make_item(CMD_TEST_BIT,  4095, '0, MSZ_8));
        send_item(make_item(CMD_SET_MASK,  4089, '1, MSZ_8));
        set_size(BITS_IN_USE_RST);
    endtask

    task automatic test_pause_until_drained();
        repeat (40) send_item(random_request());
        drain_results();
        repeat (40) send_item(random_request());
    endtask

    task automatic test_random_phases();
        logic [CFG_W-1:0] sizes [7];
        sizes = '{BITS_IN_USE_RST, 13'd1, CFG_W'(CFG_MAX), 13'd0,
                  CFG_W'($urandom_range(1, CFG_MAX)), 13'd300, 13'd64};
        foreach (sizes[p]) begin
            set_size(sizes[p]);
            no_idle = (p == 4);
            repeat (175) send_item(random_request());
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        fail_count = 0;
        no_idle    = 1'b0;
        foreach (bit_store[k])
            bit_store[k] = '0;
        size_reg = BITS_IN_USE_RST;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_items();
        test_size_register();
        test_pause_until_drained();
        test_random_phases();
        drain_results();

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
